FILE: hdl/tcpq_pkg.sv
package tcpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int OCC_W           = 5;
    localparam int STATUS_W        = 2;

    // op codes carried in the input tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_POP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL_DROP  = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic push;
        logic pop;
    } chain_ctl_t;

endpackage

FILE: hdl/two_class_priority_queue.sv
// an accepted input beat has its result beat in the output register in the cycle after it is taken
// one item per cycle while the output register is drained; each queue is a row of cells that shifts on pop
// an input beat is taken whenever the output register is empty or being drained
// reset: synchronous active-low aresetn empties both queues and the output register
// cell contents are not reset; a pop only reads cells that a push filled
module two_class_priority_queue #(
    parameter int QUEUE_DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [0] op, [1] high_class
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] pop_value, [36:32] high_occupancy,
                                   // [41:37] normal_occupancy, rest zero
    output logic [2:0]  m_tuser    // [1:0] status, [2] served_high
);
    import tcpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    logic       accept;
    logic       op;
    logic       high_class;
    value_t     push_value;

    chain_ctl_t high_ctl;
    chain_ctl_t normal_ctl;
    value_t     high_head;
    value_t     normal_head;
    logic [CNT_W-1:0] high_count;
    logic [CNT_W-1:0] normal_count;
    logic [CNT_W-1:0] high_count_after;
    logic [CNT_W-1:0] normal_count_after;
    logic [EXT_W-1:0] high_ext;
    logic [EXT_W-1:0] normal_ext;
    logic       high_full;
    logic       normal_full;
    logic       high_empty;
    logic       normal_empty;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    value_t                pop_value_reg;
    value_t                pop_value_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic                  served_high_reg;
    logic                  served_high_next;
    logic [OCC_W-1:0]      high_occ_reg;
    logic [OCC_W-1:0]      high_occ_next;
    logic [OCC_W-1:0]      normal_occ_reg;
    logic [OCC_W-1:0]      normal_occ_next;

    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign op         = s_tuser[0];
    assign high_class = s_tuser[1];
    assign push_value = s_tdata;

    assign high_full    = (high_count == CNT_W'(QUEUE_DEPTH));
    assign normal_full  = (normal_count == CNT_W'(QUEUE_DEPTH));
    assign high_empty   = (high_count == '0);
    assign normal_empty = (normal_count == '0);

    always_comb begin
        high_ctl   = '0;
        normal_ctl = '0;
        if (accept) begin
            if (op == OP_PUSH) begin
                high_ctl.push   = high_class && !high_full;
                normal_ctl.push = !high_class && !normal_full;
            end else begin
                high_ctl.pop    = !high_empty;
                normal_ctl.pop  = high_empty && !normal_empty;
            end
        end
    end

    tcpq_chain #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_high (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (high_ctl),
        .push_value (push_value),
        .head_value (high_head),
        .count      (high_count)
    );

    tcpq_chain #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_normal (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (normal_ctl),
        .push_value (push_value),
        .head_value (normal_head),
        .count      (normal_count)
    );

    // occupancy after this item, wrapped to the field width
    always_comb begin
        high_count_after   = high_count;
        normal_count_after = normal_count;
        if (high_ctl.push) begin
            high_count_after = high_count + CNT_W'(1);
        end else if (high_ctl.pop) begin
            high_count_after = high_count - CNT_W'(1);
        end
        if (normal_ctl.push) begin
            normal_count_after = normal_count + CNT_W'(1);
        end else if (normal_ctl.pop) begin
            normal_count_after = normal_count - CNT_W'(1);
        end
    end

    assign high_ext   = EXT_W'(high_count_after);
    assign normal_ext = EXT_W'(normal_count_after);

    always_comb begin
        m_valid_next     = m_valid_reg;
        pop_value_next   = pop_value_reg;
        status_next      = status_reg;
        served_high_next = served_high_reg;
        high_occ_next    = high_occ_reg;
        normal_occ_next  = normal_occ_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next     = 1'b1;
            pop_value_next   = '0;
            status_next      = ST_OK;
            served_high_next = 1'b0;
            high_occ_next    = high_ext[OCC_W-1:0];
            normal_occ_next  = normal_ext[OCC_W-1:0];
            if (op == OP_PUSH) begin
                if (high_class ? high_full : normal_full) begin
                    status_next = ST_FULL_DROP;
                end
            end else if (!high_empty) begin
                pop_value_next   = high_head;
                served_high_next = 1'b1;
            end else if (!normal_empty) begin
                pop_value_next   = normal_head;
            end else begin
                status_next      = ST_EMPTY_POP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_value_reg   <= pop_value_next;
        status_reg      <= status_next;
        served_high_reg <= served_high_next;
        high_occ_reg    <= high_occ_next;
        normal_occ_reg  <= normal_occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, normal_occ_reg, high_occ_reg, pop_value_reg};
    assign m_tuser  = {served_high_reg, status_reg};

endmodule

FILE: hdl/tcpq_cell.sv
module tcpq_cell (
    input  logic            aclk,
    input  logic            load,
    input  logic            shift,
    input  tcpq_pkg::value_t load_value,
    input  tcpq_pkg::value_t shift_value,
    output tcpq_pkg::value_t value
);
    import tcpq_pkg::*;

    value_t value_reg;
    value_t value_next;

    always_comb begin
        value_next = value_reg;
        if (load) begin
            value_next = load_value;
        end else if (shift) begin
            value_next = shift_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: hdl/tcpq_chain.sv
module tcpq_chain #(
    parameter int DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcpq_pkg::chain_ctl_t   ctl,
    input  tcpq_pkg::value_t       push_value,
    output tcpq_pkg::value_t       head_value,
    output logic [CNT_W-1:0]       count
);
    import tcpq_pkg::*;

    value_t cell_value [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // cell 0 is the head; a pop moves every entry one cell toward it
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        value_t from_next;
        if (i == DEPTH - 1) begin : g_last
            assign from_next = cell_value[i];
        end else begin : g_mid
            assign from_next = cell_value[i+1];
        end
        tcpq_cell u_cell (
            .aclk        (aclk),
            .load        (ctl.push && (count_reg == CNT_W'(i))),
            .shift       (ctl.pop),
            .load_value  (push_value),
            .shift_value (from_next),
            .value       (cell_value[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_value = cell_value[0];
    assign count      = count_reg;

endmodule
